/* hw/rtl/e2ep11_pkg.sv */
// Package for the frame protect/check block: configuration struct, result struct,
// register indexes, status codes and the bytewise crc-8 update.
// No dependencies.
package e2ep11_pkg;

   // default frame length held by the position counter
   localparam int MaxFrameBytesDefault = 4096;

   // configuration register indexes
   localparam logic [2:0] REG_OPERATION   = 3'd0;
   localparam logic [2:0] REG_INCREMENT   = 3'd1;
   localparam logic [2:0] REG_DATA_ID     = 3'd2;
   localparam logic [2:0] REG_NIBBLE_MODE = 3'd3;
   localparam logic [2:0] REG_HDR_OFFSET  = 3'd4;

   // operation codes
   localparam logic OP_PROTECT = 1'b0;
   localparam logic OP_CHECK   = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_OUTSIDE     = 3'd1;
   localparam logic [2:0] ST_COUNTER_BAD = 3'd2;
   localparam logic [2:0] ST_NIBBLE_BAD  = 3'd3;
   localparam logic [2:0] ST_CRC_BAD     = 3'd4;

   // crc polynomial (x^8 + x^4 + x^3 + x^2 + 1), msb first
   localparam logic [7:0] CRC_POLY = 8'h1D;

   // largest counter value allowed in the header nibble
   localparam logic [3:0] CNT_MAX = 4'd14;
   localparam logic [4:0] CNT_MOD = 5'd15;

   typedef struct packed {
      logic        operation;
      logic        alive_step;
      logic [15:0] data_id;
      logic        nibble_mode;
      logic [11:0] header_offset;
   } cfg_type;

   typedef struct packed {
      logic [7:0] crc_value;
      logic [7:0] header_byte;
      logic [2:0] status;
   } result_type;

   // one byte through the crc register, eight shift steps
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/e2e_p11_frame_protect_check.sv */
// Top level of the frame protect/check block: input register, engine, result register.
// Depends on e2ep11_pkg, e2ep11_csr and e2ep11_engine.
//
//   channel   direction  signals                                      handshake
//   req_      in         req_data_byte, req_last_byte                 valid / stall
//   rsp_      out        rsp_crc_value, rsp_header_byte, rsp_status   valid / stall
//   csr_      in         csr_index, csr_wdata                         valid / ready
//
// One byte per cycle sustained while req_stall is low; a byte is held in the input
// register; its crc update and header logic run in the cycle it leaves the register.
// A frame's result is loaded into the result register at the end of the cycle in which
// its last byte is processed. Synchronous reset clears all control state and sets the
// configuration to its reset values. req_stall rises only when a last byte waits in the
// input register while an earlier result is still held by rsp_stall.
module e2e_p11_frame_protect_check #(
   parameter int MAX_FRAME_BYTES = e2ep11_pkg::MaxFrameBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_crc_value,
   output logic [7:0]  rsp_header_byte,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import e2ep11_pkg::*;

   cfg_type    cfg;
   result_type eng_result;
   result_type out_ff;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_vld_ff, out_vld_in;
   logic       advance, req_take, out_load;

   // configuration registers
   e2ep11_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // a held byte moves on unless it would produce a result into a full, stalled output
   assign advance   = !(in_last_ff && out_vld_ff && rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign out_load  = in_vld_ff && advance && in_last_ff;

   // input register
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // frame engine
   e2ep11_engine #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (in_vld_ff && advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (eng_result)
   );

   // result register
   always_comb begin
      out_vld_in = out_vld_ff && rsp_stall;
      if (out_load) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= eng_result;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_crc_value   = out_ff.crc_value;
   assign rsp_header_byte = out_ff.header_byte;
   assign rsp_status      = out_ff.status;

   // a last byte never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && in_last_ff && out_vld_ff && rsp_stall) |-> req_stall)
      else $error("result register overwritten while stalled");

   // status stays within its defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_CRC_BAD))
      else $error("undefined status code");

   // a frame without a header reports a zero header byte
   a_outside_hdr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OUTSIDE) |-> (rsp_header_byte == 8'h00))
      else $error("header byte not cleared for short frame");

   // protect mode only reports ok or a short frame
   a_protect_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cfg.operation == OP_PROTECT) |->
         (rsp_status == ST_OK || rsp_status == ST_OUTSIDE))
      else $error("check status in protect mode");

endmodule

/* hw/rtl/e2ep11_csr.sv */
// Configuration registers of the frame protect/check block, written over the csr port.
// Depends on e2ep11_pkg.
module e2ep11_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   output e2ep11_pkg::cfg_type  cfg
);
   import e2ep11_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_OPERATION:   cfg_in.operation     = csr_wdata[0];
            REG_INCREMENT:   cfg_in.alive_step    = csr_wdata[0];
            REG_DATA_ID:     cfg_in.data_id       = csr_wdata;
            REG_NIBBLE_MODE: cfg_in.nibble_mode   = csr_wdata[0];
            REG_HDR_OFFSET:  cfg_in.header_offset = csr_wdata[11:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.operation     <= OP_PROTECT;
         cfg_ff.alive_step    <= 1'b1;
         cfg_ff.data_id       <= '0;
         cfg_ff.nibble_mode   <= 1'b0;
         cfg_ff.header_offset <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/e2ep11_engine.sv */
// Per-frame state and byte processing: crc update, header rewrite or check, and the
// result at the last byte. Depends on e2ep11_pkg.
module e2ep11_engine #(
   parameter int MAX_FRAME_BYTES = e2ep11_pkg::MaxFrameBytesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  e2ep11_pkg::cfg_type    cfg,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output e2ep11_pkg::result_type result
);
   import e2ep11_pkg::*;

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMP_W = (POS_W > 13) ? POS_W : 13;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       rcrc_ff, rcrc_in;
   logic [7:0]       hdr_ff, hdr_in;
   logic             cnt_bad_ff, cnt_bad_in;
   logic             nib_bad_ff, nib_bad_in;

   logic [7:0]       seed, crc_cur, b_eff, crc_upd;
   logic [CMP_W-1:0] pos_x, pos_inc_x, off_x;
   logic             in_frame, is_crc, is_hdr;
   logic [4:0]       cnt_sum;
   logic [3:0]       cnt_new;
   logic [3:0]       nib_new;

   // seed from data id: low byte, then high byte or zero
   assign seed = crc8_byte(crc8_byte(8'h00, cfg.data_id[7:0]),
                           cfg.nibble_mode ? 8'h00 : cfg.data_id[15:8]);

   assign crc_cur  = (pos_ff == '0) ? seed : crc_ff;
   assign pos_x    = CMP_W'(pos_ff);
   assign off_x    = CMP_W'(cfg.header_offset);
   assign in_frame = pos_ff < POS_LIMIT;
   assign is_crc   = pos_x == off_x;
   assign is_hdr   = pos_x == off_x + CMP_W'(1);

   // counter nibble: (count + 1) mod 15
   assign cnt_sum = {1'b0, data_byte[3:0]} + 5'd1;
   assign cnt_new = (cnt_sum >= CNT_MOD) ? 4'(cnt_sum - CNT_MOD) : cnt_sum[3:0];
   assign nib_new = cfg.nibble_mode ? cfg.data_id[11:8] : data_byte[7:4];

   // byte that enters the crc
   always_comb begin
      b_eff = data_byte;
      if (is_hdr && cfg.operation == OP_PROTECT) begin
         b_eff = {nib_new, cfg.alive_step ? cnt_new : data_byte[3:0]};
      end
   end

   assign crc_upd = crc8_byte(crc_cur, b_eff);

   // frame state update
   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_cur;
      rcrc_in    = rcrc_ff;
      hdr_in     = hdr_ff;
      cnt_bad_in = cnt_bad_ff;
      nib_bad_in = nib_bad_ff;
      if (in_frame) begin
         pos_in = pos_ff + POS_W'(1);
         if (is_crc) begin
            rcrc_in = data_byte;
         end else begin
            crc_in = crc_upd;
            if (is_hdr) begin
               hdr_in = b_eff;
               if (cfg.operation == OP_CHECK) begin
                  cnt_bad_in = data_byte[3:0] > CNT_MAX;
                  nib_bad_in = cfg.nibble_mode && (data_byte[7:4] != cfg.data_id[11:8]);
               end
            end
         end
      end
   end

   // result from the updated state
   assign pos_inc_x = CMP_W'(pos_in);
   always_comb begin
      result.crc_value   = crc_in;
      result.header_byte = hdr_in;
      if (pos_inc_x < off_x + CMP_W'(2)) begin
         result.status      = ST_OUTSIDE;
         result.header_byte = 8'h00;
      end else if (cfg.operation == OP_CHECK) begin
         if (cnt_bad_in) begin
            result.status = ST_COUNTER_BAD;
         end else if (nib_bad_in) begin
            result.status = ST_NIBBLE_BAD;
         end else if (crc_in != rcrc_in) begin
            result.status = ST_CRC_BAD;
         end else begin
            result.status = ST_OK;
         end
      end else begin
         result.status = ST_OK;
      end
   end

   // frame registers, cleared (the crc set to the seed) after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= '0;
         rcrc_ff    <= '0;
         hdr_ff     <= '0;
         cnt_bad_ff <= 1'b0;
         nib_bad_ff <= 1'b0;
      end else if (step) begin
         if (last_byte) begin
            pos_ff     <= '0;
            crc_ff     <= seed;
            rcrc_ff    <= '0;
            hdr_ff     <= '0;
            cnt_bad_ff <= 1'b0;
            nib_bad_ff <= 1'b0;
         end else begin
            pos_ff     <= pos_in;
            crc_ff     <= crc_in;
            rcrc_ff    <= rcrc_in;
            hdr_ff     <= hdr_in;
            cnt_bad_ff <= cnt_bad_in;
            nib_bad_ff <= nib_bad_in;
         end
      end
   end

endmodule
